// ----- hw/rtl/srm_pkg.sv -----
// Shared constants, types and register codes for the step response metrics block.
// Depends on nothing; every other file in hw/rtl imports it.
package srm_pkg;

    // Record length limit and sample index width
    localparam int MAX_SAMPLES = 4096;
    localparam int IDX_W       = $clog2(MAX_SAMPLES);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_SAMPLES - 1);

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int SP_W       = 14;
    localparam int PERIOD_W   = 20;
    localparam int TIME_W     = 32;
    localparam int OVER_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 1'd1;
    localparam logic [SP_W-1:0]      SP_RESET     = 14'd4096;
    localparam logic [PERIOD_W-1:0]  PERIOD_RESET = 20'd10000;

    // Peak tracker starts at the most negative sample
    localparam logic signed [SAMPLE_W-1:0] PEAK_MIN = 16'sh8000;

    // Overshoot arithmetic: (peak - setpoint) * 10000 / setpoint
    localparam int DIFF_W     = 15;
    localparam int SCALE_W    = 14;
    localparam logic [PERIOD_W-1:0] OVER_SCALE = 20'd10000;
    localparam int NUM_W      = DIFF_W + SCALE_W;
    localparam int DIV_CNT_W  = $clog2(NUM_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = DIV_CNT_W'(NUM_W - 1);

    // Shared multiplier operand widths
    localparam int CNT_W   = IDX_W + 1;
    localparam int MUL_A_W = (CNT_W > DIFF_W) ? CNT_W : DIFF_W;
    localparam int PROD_W  = MUL_A_W + PERIOD_W;

    // Summary queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);

    // One finished record, as the front hands it to the back
    typedef struct packed {
        logic              rise_reached;
        logic              not_settled;
        logic              over_en;
        logic              over_zero_sp;
        logic [IDX_W-1:0]  rise_cnt;
        logic [CNT_W-1:0]  settle_cnt;
        logic [DIFF_W-1:0] over_diff;
    } t_summary;

endpackage

// ----- hw/rtl/srm_front.sv -----
// Front end: accepts samples, tracks crossings, peak and band exits per record.
// Depends on srm_pkg; pushes one t_summary per record into srm_queue.
module srm_front import srm_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_last,
    input  logic [SP_W-1:0]            i_setpoint,
    input  logic                       i_full,
    output logic                       o_stall,
    output logic                       o_push,
    output t_summary                   o_sum
);

    logic [IDX_W-1:0]            r_idx, r_lo_idx, r_hi_idx, r_out_idx;
    logic                        r_lo_found, r_hi_found, r_any;
    logic signed [SAMPLE_W-1:0]  r_peak;

    logic [IDX_W-1:0]            n_lo_idx, n_hi_idx, n_out_idx;
    logic                        n_lo_found, n_hi_found, n_any;
    logic signed [SAMPLE_W-1:0]  n_peak;

    logic                        s_accept;
    logic signed [21:0]          s_x10, s_sp, s_sp_x9;
    logic signed [16:0]          s_diff, s_pk_diff;
    logic [15:0]                 s_mag;
    logic [21:0]                 s_mag_x50;
    logic                        s_lo_hit, s_hi_hit, s_outside, s_reached;

    assign o_stall  = i_full;
    assign s_accept = i_valid & ~i_full;

    // Threshold and band tests on the incoming sample
    always_comb begin
        s_x10     = 22'(i_sample) * 22'sd10;
        s_sp      = $signed({8'b0, i_setpoint});
        s_sp_x9   = $signed(22'(i_setpoint) * 22'd9);
        s_lo_hit  = s_x10 >= s_sp;
        s_hi_hit  = s_x10 >= s_sp_x9;
        s_diff    = 17'(i_sample) - $signed({3'b0, i_setpoint});
        s_mag     = s_diff[16] ? 16'(-s_diff) : s_diff[15:0];
        s_mag_x50 = 22'(s_mag) * 22'd50;
        s_outside = s_mag_x50 > 22'(i_setpoint);
    end

    // Record state including the current sample
    always_comb begin
        n_lo_found = r_lo_found | s_lo_hit;
        n_lo_idx   = (!r_lo_found && s_lo_hit) ? r_idx : r_lo_idx;
        n_hi_found = r_hi_found | s_hi_hit;
        n_hi_idx   = (!r_hi_found && s_hi_hit) ? r_idx : r_hi_idx;
        n_peak     = (i_sample > r_peak) ? i_sample : r_peak;
        n_any      = r_any | s_outside;
        n_out_idx  = s_outside ? r_idx : r_out_idx;
    end

    // Summary for the back end, valid on the final sample
    always_comb begin
        s_reached          = n_lo_found & n_hi_found;
        s_pk_diff          = 17'(n_peak) - $signed({3'b0, i_setpoint});
        o_sum.rise_reached = s_reached;
        o_sum.not_settled  = s_outside;
        o_sum.over_en      = s_pk_diff > 17'sd0;
        o_sum.over_zero_sp = (i_setpoint == '0);
        o_sum.rise_cnt     = (s_reached && (n_hi_idx >= n_lo_idx)) ?
                             (n_hi_idx - n_lo_idx) : '0;
        o_sum.settle_cnt   = (!s_outside && n_any) ? (CNT_W'(n_out_idx) + CNT_W'(1)) : '0;
        o_sum.over_diff    = s_pk_diff[DIFF_W-1:0];
    end

    assign o_push = s_accept & i_last;

    // Per-record state; cleared at reset and after the final sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (s_accept && i_last)) begin
            r_idx      <= '0;
            r_lo_idx   <= '0;
            r_lo_found <= 1'b0;
            r_hi_idx   <= '0;
            r_hi_found <= 1'b0;
            r_peak     <= PEAK_MIN;
            r_out_idx  <= '0;
            r_any      <= 1'b0;
        end else if (s_accept) begin
            if (r_idx != IDX_MAX) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            r_lo_idx   <= n_lo_idx;
            r_lo_found <= n_lo_found;
            r_hi_idx   <= n_hi_idx;
            r_hi_found <= n_hi_found;
            r_peak     <= n_peak;
            r_out_idx  <= n_out_idx;
            r_any      <= n_any;
        end
    end

endmodule

// ----- hw/rtl/srm_queue.sv -----
// Short register FIFO of record summaries between front and back end.
// Depends on srm_pkg for t_summary and the queue depth.
module srm_queue import srm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_summary i_data,
    input  logic     i_pop,
    output logic     o_full,
    output logic     o_empty,
    output t_summary o_data
);

    t_summary             r_mem [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr, r_rd;
    logic [Q_PTR_W:0]     r_cnt;

    assign o_full  = (r_cnt == (Q_PTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    // Storage; push is only issued when not full
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (Q_PTR_W+1)'(1);
                2'b01:   r_cnt <= r_cnt - (Q_PTR_W+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- hw/rtl/srm_back.sv -----
// Back end: scales counts by the sample period and divides out the overshoot.
// Depends on srm_pkg; pops summaries from srm_queue, drives the result channel.
module srm_back import srm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_sum_valid,
    input  t_summary            i_sum,
    output logic                o_pop,
    input  logic [SP_W-1:0]     i_setpoint,
    input  logic [PERIOD_W-1:0] i_period,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [TIME_W-1:0]   o_rise_time_us,
    output logic                o_rise_reached,
    output logic [TIME_W-1:0]   o_settling_time_us,
    output logic                o_not_settled,
    output logic [OVER_W-1:0]   o_overshoot_centi_pct
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RISE,
        S_SETTLE,
        S_OVER,
        S_DIV,
        S_OUT
    } t_state;

    t_state                 r_state;
    t_summary               r_sum;
    logic [TIME_W-1:0]      r_rise, r_settle;
    logic [NUM_W-1:0]       r_num;
    logic [SP_W-1:0]        r_rem;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic                   r_o_valid;

    logic [MUL_A_W-1:0]     s_mul_a;
    logic [PERIOD_W-1:0]    s_mul_b;
    logic [PROD_W-1:0]      s_prod;
    logic [TIME_W-1:0]      s_time;
    logic [SP_W:0]          s_rem_sh;
    logic                   s_qbit;
    logic [OVER_W-1:0]      s_over;

    assign o_pop   = (r_state == S_IDLE) && i_sum_valid;
    assign o_valid = r_o_valid;

    // Shared multiplier: counts by the period, then the overshoot by 10000
    always_comb begin
        case (r_state)
            S_RISE: begin
                s_mul_a = MUL_A_W'(r_sum.rise_cnt);
                s_mul_b = i_period;
            end
            S_SETTLE: begin
                s_mul_a = MUL_A_W'(r_sum.settle_cnt);
                s_mul_b = i_period;
            end
            default: begin
                s_mul_a = MUL_A_W'(r_sum.over_diff);
                s_mul_b = OVER_SCALE;
            end
        endcase
        s_prod = PROD_W'(s_mul_a) * PROD_W'(s_mul_b);
        s_time = (|s_prod[PROD_W-1:TIME_W]) ? '1 : s_prod[TIME_W-1:0];
    end

    // One restoring division step per cycle
    always_comb begin
        s_rem_sh = {r_rem, r_num[NUM_W-1]};
        s_qbit   = s_rem_sh >= {1'b0, i_setpoint};
    end

    // Overshoot with zero setpoint and quotient saturation
    always_comb begin
        if (!r_sum.over_en) begin
            s_over = '0;
        end else if (r_sum.over_zero_sp || (|r_num[NUM_W-1:OVER_W])) begin
            s_over = '1;
        end else begin
            s_over = r_num[OVER_W-1:0];
        end
    end

    // Sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && !i_stall && (r_state != S_OUT)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_sum_valid) begin
                        r_sum   <= i_sum;
                        r_state <= S_RISE;
                    end
                end
                S_RISE: begin
                    r_rise  <= s_time;
                    r_state <= S_SETTLE;
                end
                S_SETTLE: begin
                    r_settle <= s_time;
                    r_state  <= S_OVER;
                end
                S_OVER: begin
                    r_num   <= s_prod[NUM_W-1:0];
                    r_rem   <= '0;
                    r_cnt   <= DIV_LAST_STEP;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_num <= {r_num[NUM_W-2:0], s_qbit};
                    r_rem <= s_qbit ? SP_W'(s_rem_sh - {1'b0, i_setpoint}) : s_rem_sh[SP_W-1:0];
                    r_cnt <= r_cnt - DIV_CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_o_valid || !i_stall) begin
                        o_rise_time_us        <= r_rise;
                        o_rise_reached        <= r_sum.rise_reached;
                        o_settling_time_us    <= r_settle;
                        o_not_settled         <= r_sum.not_settled;
                        o_overshoot_centi_pct <= s_over;
                        r_o_valid             <= 1'b1;
                        r_state               <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/step_response_metrics.sv -----
// Step response metrics: rise time, settling time and overshoot of a sample record.
// Depends on srm_pkg, srm_front, srm_queue and srm_back.
//
// Usage:
//   Input channel (i_valid / o_stall): one signed Q3.12 sample per request, i_last set
//   on the final sample of a record. A request is taken on an edge with i_valid high
//   and o_stall low. Samples are taken one per cycle while o_stall is low.
//   Result channel (o_valid / i_stall): one request per record, held until taken.
//   Configuration: i_cfg_we with i_cfg_idx 0 writes the setpoint (i_cfg_data[13:0]),
//   index 1 the sample period in microseconds. Write only while the block is idle.
// Sequence: the final sample's summary is pushed into the queue; the back end pops it,
//   uses the shared multiplier for rise time, settling time and overshoot, runs a
//   bit-per-cycle overshoot division and loads the output register before the next pop.
// Throughput: one sample per cycle while o_stall is low; a two-entry summary queue
//   absorbs back-end work; o_stall rises only when short records or a result stall fill it.
// Reset: synchronous, active low; clears record state, queue and result valid, and
//   restores setpoint 4096 and period 10000.
// Receiver stall: the result holds; once the queue fills, o_stall goes high.
module step_response_metrics import srm_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_last,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [TIME_W-1:0]          o_rise_time_us,
    output logic                       o_rise_reached,
    output logic [TIME_W-1:0]          o_settling_time_us,
    output logic                       o_not_settled,
    output logic [OVER_W-1:0]          o_overshoot_centi_pct,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    logic [SP_W-1:0]     r_setpoint;
    logic [PERIOD_W-1:0] r_period;

    logic     s_push, s_pop, s_full, s_empty;
    t_summary s_sum_in, s_sum_out;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= SP_RESET;
            r_period   <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SETPOINT: r_setpoint <= i_cfg_data[SP_W-1:0];
                CFG_PERIOD:   r_period   <= i_cfg_data[PERIOD_W-1:0];
                default:      r_period   <= r_period;
            endcase
        end
    end

    srm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_sample   (i_sample),
        .i_last     (i_last),
        .i_setpoint (r_setpoint),
        .i_full     (s_full),
        .o_stall    (o_stall),
        .o_push     (s_push),
        .o_sum      (s_sum_in)
    );

    srm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_data  (s_sum_in),
        .i_pop   (s_pop),
        .o_full  (s_full),
        .o_empty (s_empty),
        .o_data  (s_sum_out)
    );

    srm_back u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_sum_valid           (~s_empty),
        .i_sum                 (s_sum_out),
        .o_pop                 (s_pop),
        .i_setpoint            (r_setpoint),
        .i_period              (r_period),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_rise_time_us        (o_rise_time_us),
        .o_rise_reached        (o_rise_reached),
        .o_settling_time_us    (o_settling_time_us),
        .o_not_settled         (o_not_settled),
        .o_overshoot_centi_pct (o_overshoot_centi_pct)
    );

endmodule

// ----- hw/rtl/srm_checker.sv -----
// Port-level checks for step_response_metrics, bound to the top level.
// Depends on srm_pkg for field widths.
module srm_checker import srm_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_stall,
    input logic [TIME_W-1:0]   o_rise_time_us,
    input logic                o_rise_reached,
    input logic [TIME_W-1:0]   o_settling_time_us,
    input logic                o_not_settled,
    input logic [OVER_W-1:0]   o_overshoot_centi_pct
);

    // No result request in the cycle after reset
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A stalled result request holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rise_time_us)
            && $stable(o_settling_time_us) && $stable(o_overshoot_centi_pct)
            && $stable(o_rise_reached) && $stable(o_not_settled))
        else $error("stalled result changed");

    // Rise time is zero unless both thresholds were reached
    a_rise_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_rise_reached |-> o_rise_time_us == '0)
        else $error("rise time without both crossings");

    // An unsettled record reports zero settling time
    a_settle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_not_settled |-> o_settling_time_us == '0)
        else $error("settling time on unsettled record");

endmodule

bind step_response_metrics srm_checker u_srm_checker (.*);
